### design/srec_pkg.sv
// shared types, constants and helpers for the s-record encoder
// no dependencies
`default_nettype none

package srec_pkg;

  // bytes gathered before a data record goes out
  localparam int LINE_BYTES = 16;
  localparam int BUF_DEPTH  = 16;
  localparam int IDX_W      = $clog2(BUF_DEPTH);
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);

  // register indexes of the configuration port
  localparam logic REG_RECORD_TYPE  = 1'b0;
  localparam logic REG_LOAD_ADDRESS = 1'b1;

  // record type codes
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_S1   = 2'd1;
  localparam logic [1:0] TYPE_S2   = 2'd2;
  localparam logic [1:0] TYPE_S3   = 2'd3;

  localparam logic [7:0] CHAR_S       = 8'h53;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_TERM_BASE = 8'h3A;  // '0' + 10

  // one record for the character sequencer
  typedef struct packed {
    logic [7:0]       digit;   // ascii type digit after 'S'
    logic [31:0]      addr;    // record address, already masked
    logic [CNT_W-1:0] ndata;   // data bytes taken from the line buffer
    logic [2:0]       nb;      // address bytes: 2, 3 or 4
    logic             last;    // final character ends the transaction run
  } rec_cmd_t;

  function automatic logic [31:0] addr_mask(input logic [1:0] t);
    logic [31:0] m;
    unique case (t)
      TYPE_S2: m = 32'h00FF_FFFF;
      TYPE_S3: m = 32'hFFFF_FFFF;
      default: m = 32'h0000_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] addr_bytes(input logic [1:0] t);
    logic [2:0] n;
    unique case (t)
      TYPE_S2: n = 3'd3;
      TYPE_S3: n = 3'd4;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = CHAR_ZERO + {4'd0, v};
    else           c = CHAR_A + {4'd0, v} - 8'd10;
    return c;
  endfunction

endpackage

`default_nettype wire

### design/srecord_encoder_top.sv
// s-record encoder top: stream control, line buffer and record sequencer
// a transaction loads the sequencer; its output register then gets the first character,
// then one character a cycle while char_stall is low; a data record of n bytes is
// 7+2*nb+2*n characters (nb = 2, 3 or 4 address bytes), the termination record 7+2*nb
// the item channel stalls while a record is printed; items with no flag start no record
// reset: synchronous, clears stream state, record_type to s1 and load_address to zero
`default_nettype none

module srecord_encoder_top
  import srec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_stream,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [7:0]       out_char,
  output logic             last_of_run
);

  logic [1:0]       record_type;
  logic [31:0]      load_address;
  logic             stream_started;
  logic [1:0]       active_type;
  logic [31:0]      start_address;
  logic [31:0]      current_address;
  logic [CNT_W-1:0] line_count;
  logic             busy;
  logic             pending_term;

  logic             accept;
  logic [1:0]       eff_type;
  logic [31:0]      eff_mask;
  logic [31:0]      eff_start;
  logic [31:0]      eff_cur;
  logic [CNT_W-1:0] count_after;
  logic             flush;
  logic             gen_start;
  rec_cmd_t         gen_cmd;
  logic             gen_done;
  logic             rd_en;
  logic [IDX_W-1:0] rd_index;
  logic [7:0]       rd_data;

  assign item_stall = busy;
  assign accept = item_valid && !item_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      record_type <= TYPE_S1;
      load_address <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RECORD_TYPE:  record_type <= cfg_data[1:0];
        REG_LOAD_ADDRESS: load_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // stream values seen by this transaction
  always_comb begin
    if (stream_started) begin
      eff_type = active_type;
    end else begin
      eff_type = (record_type == TYPE_NONE) ? TYPE_S1 : record_type;
    end
    eff_mask = addr_mask(eff_type);
    eff_start = stream_started ? start_address : (load_address & eff_mask);
    eff_cur = stream_started ? current_address : eff_start;
    count_after = (stream_started ? line_count : '0) + {{(CNT_W-1){1'b0}}, has_byte};
    flush = (has_byte && (count_after >= CNT_W'(LINE_BYTES)))
         || (end_of_stream && (count_after != '0));
  end

  // record launch
  always_comb begin
    gen_start = 1'b0;
    gen_cmd.digit = CHAR_ZERO + {6'd0, eff_type};
    gen_cmd.addr = eff_cur;
    gen_cmd.ndata = count_after;
    gen_cmd.nb = addr_bytes(eff_type);
    gen_cmd.last = !end_of_stream;
    priority if (accept && flush) begin
      gen_start = 1'b1;
    end else if (accept && end_of_stream) begin
      gen_start = 1'b1;
      gen_cmd.digit = CHAR_TERM_BASE - {6'd0, eff_type};
      gen_cmd.addr = eff_start;
      gen_cmd.ndata = '0;
      gen_cmd.last = 1'b1;
    end else if (gen_done && pending_term) begin
      gen_start = 1'b1;
      gen_cmd.digit = CHAR_TERM_BASE - {6'd0, active_type};
      gen_cmd.addr = start_address;
      gen_cmd.ndata = '0;
      gen_cmd.nb = addr_bytes(active_type);
      gen_cmd.last = 1'b1;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_started <= 1'b0;
      active_type <= TYPE_S1;
      start_address <= 32'd0;
      current_address <= 32'd0;
      line_count <= '0;
      busy <= 1'b0;
      pending_term <= 1'b0;
    end else if (accept) begin
      if (has_byte || end_of_stream) begin
        active_type <= eff_type;
        start_address <= eff_start;
        if (flush) begin
          current_address <= (eff_cur + {{(32-CNT_W){1'b0}}, count_after}) & eff_mask;
          line_count <= '0;
        end else begin
          current_address <= eff_cur;
          line_count <= count_after;
        end
        if (end_of_stream) begin
          stream_started <= 1'b0;
          line_count <= '0;
        end else begin
          stream_started <= 1'b1;
        end
        busy <= gen_start;
        pending_term <= flush && end_of_stream;
      end
    end else if (gen_done) begin
      pending_term <= 1'b0;
      busy <= pending_term;
    end
  end

  srec_line_buf #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk      (clk),
    .wr_en    (accept && has_byte),
    .wr_index ((stream_started ? line_count[IDX_W-1:0] : '0)),
    .wr_data  (data_byte),
    .rd_en    (rd_en),
    .rd_index (rd_index),
    .rd_data  (rd_data)
  );

  srec_record_gen u_gen (
    .clk         (clk),
    .rst         (rst),
    .start       (gen_start),
    .cmd         (gen_cmd),
    .done        (gen_done),
    .rd_en       (rd_en),
    .rd_index    (rd_index),
    .rd_data     (rd_data),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### design/srec_line_buf.sv
// generic ram: one write port and one registered read port with read enable
// no dependencies
`default_nettype none

module srec_line_buf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_index,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_index,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] entry [DEPTH];

  // word write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_index] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= entry[rd_index];
    end
  end

endmodule

`default_nettype wire

### design/srec_record_gen.sv
// character sequencer: emits one s-record, one character a cycle unless stalled,
// with a shared 8-bit adder building the checksum; depends on srec_pkg
`default_nettype none

module srec_record_gen
  import srec_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire rec_cmd_t         cmd,
  output logic                  done,
  output logic                  rd_en,
  output logic      [IDX_W-1:0] rd_index,
  input  wire logic [7:0]       rd_data,
  output logic                  char_valid,
  input  wire logic             char_stall,
  output logic      [7:0]       out_char,
  output logic                  last_of_run
);

  localparam logic [2:0] ST_S     = 3'd0;
  localparam logic [2:0] ST_DIGIT = 3'd1;
  localparam logic [2:0] ST_CNT   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_NL    = 3'd6;

  logic             busy;
  logic [2:0]       stage;
  logic             nib;
  logic [7:0]       digit;
  logic [7:0]       cnt;
  logic [31:0]      addr_shift;
  logic [CNT_W-1:0] ndata;
  logic [CNT_W-1:0] left;
  logic             last;
  logic [7:0]       sum;

  logic       load;
  logic [7:0] cur_byte;
  logic [7:0] sum_add;
  logic [7:0] ch;

  assign load = busy && (!char_valid || !char_stall);
  assign done = load && (stage == ST_NL);
  assign sum_add = sum + cur_byte;

  // buffer read advances only with the sequencer
  assign rd_en = load;

  // byte currently being printed
  always_comb begin
    unique case (stage)
      ST_CNT:  cur_byte = cnt;
      ST_ADDR: cur_byte = addr_shift[31:24];
      ST_DATA: cur_byte = rd_data;
      default: cur_byte = ~sum;
    endcase
  end

  // character for this step
  always_comb begin
    unique case (stage)
      ST_S:     ch = CHAR_S;
      ST_DIGIT: ch = digit;
      ST_NL:    ch = CHAR_NL;
      default:  ch = hex_char(nib ? cur_byte[3:0] : cur_byte[7:4]);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      stage <= ST_S;
      nib <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      stage <= ST_S;
      nib <= 1'b0;
      digit <= cmd.digit;
      cnt <= {5'd0, cmd.nb} + {{(8-CNT_W){1'b0}}, cmd.ndata} + 8'd1;
      unique case (cmd.nb)
        3'd2:    addr_shift <= cmd.addr << 16;
        3'd3:    addr_shift <= cmd.addr << 8;
        default: addr_shift <= cmd.addr;
      endcase
      ndata <= cmd.ndata;
      left <= {{(CNT_W-3){1'b0}}, cmd.nb};
      last <= cmd.last;
      sum <= 8'd0;
      rd_index <= '0;
    end else if (load) begin
      unique case (stage)
        ST_S:     stage <= ST_DIGIT;
        ST_DIGIT: stage <= ST_CNT;
        ST_NL:    busy <= 1'b0;
        default: begin
          nib <= !nib;
          if (nib) begin
            sum <= sum_add;
            unique case (stage)
              ST_CNT: stage <= ST_ADDR;
              ST_ADDR: begin
                addr_shift <= addr_shift << 8;
                left <= left - 1'b1;
                if (left == CNT_W'(1)) begin
                  left <= ndata;
                  stage <= (ndata != '0) ? ST_DATA : ST_SUM;
                end
              end
              ST_DATA: begin
                left <= left - 1'b1;
                if (left == CNT_W'(1)) stage <= ST_SUM;
              end
              default: stage <= ST_NL;
            endcase
          end else if (stage == ST_DATA) begin
            // read data lags the index by one step, so step it on the high nibble
            rd_index <= rd_index + 1'b1;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= ch;
      last_of_run <= (stage == ST_NL) && last;
    end
  end

endmodule

`default_nettype wire
